// File: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/seglr_pkg.sv
// Types, constants and the fraction table of the segment linear resampler.
package seglr_pkg;

    localparam int DEF_FEAT_DIM = 8;
    localparam int DEF_COLUMNS  = 256;

    localparam int VAL_W  = 16;   // stored and interpolated values
    localparam int COL_W  = 8;    // column fields
    localparam int ROW_FW = 3;    // row fields
    localparam int SMP_W  = 3;    // sample index
    localparam int CNT_W  = 4;    // sample_count register
    localparam int DEN_W  = 3;    // sample_count - 1
    localparam int EXT_W  = 13;   // holds any column compared against COLUMNS

    localparam int DIV_STEPS = COL_W;
    localparam int CQ_DEPTH  = 4;
    localparam int OQ_DEPTH  = 4;

    localparam logic [CNT_W-1:0] SC_MIN   = CNT_W'(2);
    localparam logic [CNT_W-1:0] SC_MAX   = CNT_W'(8);
    localparam logic [CNT_W-1:0] SC_RESET = CNT_W'(4);

    typedef enum logic [1:0] {
        K_LOAD,
        K_SAMPLE,
        K_BAD
    } t_kind;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_back_state;

    // One classified command: a store write, a resample run or a bad segment.
    typedef struct packed {
        t_kind                   kind;
        logic [COL_W-1:0]        col;     // load column or segment start
        logic [ROW_FW-1:0]       row;
        logic signed [VAL_W-1:0] value;
        logic [DEN_W-1:0]        den;     // also the last sample index
        logic [COL_W-1:0]        q_step;  // (end-start) / den
        logic [DEN_W-1:0]        r_step;  // (end-start) % den
    } t_cmd;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [SMP_W-1:0]        smp;
        logic [ROW_FW-1:0]       row;
        logic                    last;
        logic                    bad;
    } t_res;

    // floor(rem * 65536 / den) for rem < den
    function automatic logic [VAL_W-1:0] frac_q16(input logic [DEN_W-1:0] den,
                                                  input logic [DEN_W-1:0] rem);
        logic [VAL_W-1:0] f;
        unique case ({den, rem})
            {3'd2, 3'd1}: f = 16'd32768;
            {3'd3, 3'd1}: f = 16'd21845;
            {3'd3, 3'd2}: f = 16'd43690;
            {3'd4, 3'd1}: f = 16'd16384;
            {3'd4, 3'd2}: f = 16'd32768;
            {3'd4, 3'd3}: f = 16'd49152;
            {3'd5, 3'd1}: f = 16'd13107;
            {3'd5, 3'd2}: f = 16'd26214;
            {3'd5, 3'd3}: f = 16'd39321;
            {3'd5, 3'd4}: f = 16'd52428;
            {3'd6, 3'd1}: f = 16'd10922;
            {3'd6, 3'd2}: f = 16'd21845;
            {3'd6, 3'd3}: f = 16'd32768;
            {3'd6, 3'd4}: f = 16'd43690;
            {3'd6, 3'd5}: f = 16'd54613;
            {3'd7, 3'd1}: f = 16'd9362;
            {3'd7, 3'd2}: f = 16'd18724;
            {3'd7, 3'd3}: f = 16'd28086;
            {3'd7, 3'd4}: f = 16'd37449;
            {3'd7, 3'd5}: f = 16'd46811;
            {3'd7, 3'd6}: f = 16'd56173;
            default:      f = '0;
        endcase
        return f;
    endfunction

endpackage

// File: sv/seglr_front.sv
// Front end: takes input beats, classifies them and works out the sample step.
module seglr_front import seglr_pkg::*; #(
    parameter int FEAT_DIM = DEF_FEAT_DIM,
    parameter int COLUMNS  = DEF_COLUMNS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_command,
    input  logic [COL_W-1:0]        i_column,
    input  logic [ROW_FW-1:0]       i_feature_row,
    input  logic signed [VAL_W-1:0] i_sample_value,
    input  logic [COL_W-1:0]        i_seg_start,
    input  logic [COL_W-1:0]        i_seg_end,
    input  logic [CNT_W-1:0]        i_sample_count,
    output t_cmd                    o_cmd,
    output logic                    o_push,
    input  logic                    i_q_full
);

    localparam int DC_W = $clog2(DIV_STEPS + 1);

    logic              r_hold;
    logic [DC_W-1:0]   r_cnt;
    t_cmd              r_ent;
    logic [COL_W-1:0]  r_quo;
    logic [DEN_W-1:0]  r_rem;

    logic              accept;
    logic [CNT_W-1:0]  sc;
    logic [DEN_W-1:0]  den;
    logic              col_ok;
    logic              row_ok;
    logic              seg_bad;
    logic              keep;
    t_cmd              n_ent;
    logic [DEN_W:0]    trial;
    logic              ge;

    always_comb begin
        priority if (i_sample_count < SC_MIN) begin
            sc = SC_MIN;
        end else if (i_sample_count > SC_MAX) begin
            sc = SC_MAX;
        end else begin
            sc = i_sample_count;
        end
        den     = DEN_W'(sc - CNT_W'(1));
        col_ok  = EXT_W'(i_column) < EXT_W'(COLUMNS);
        row_ok  = (CNT_W'(i_feature_row) < CNT_W'(FEAT_DIM));
        seg_bad = (i_seg_end < i_seg_start) || (EXT_W'(i_seg_end) >= EXT_W'(COLUMNS));
        // out-of-range loads are dropped here and never reach the back end
        keep    = i_command || (col_ok && row_ok);

        n_ent        = '0;
        n_ent.row    = i_feature_row;
        n_ent.value  = i_sample_value;
        n_ent.den    = den;
        if (!i_command) begin
            n_ent.kind = K_LOAD;
            n_ent.col  = i_column;
        end else begin
            n_ent.kind = seg_bad ? K_BAD : K_SAMPLE;
            n_ent.col  = i_seg_start;
        end

        o_push  = r_hold && (r_cnt == '0) && !i_q_full;
        o_ready = !r_hold || o_push;
        accept  = i_valid && o_ready;

        o_cmd        = r_ent;
        o_cmd.q_step = r_quo;
        o_cmd.r_step = r_rem;

        // restoring division, one quotient bit a cycle
        trial = {r_rem, r_quo[COL_W-1]};
        ge    = trial >= {1'b0, r_ent.den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (accept) begin
                r_hold <= keep;
                r_cnt  <= (i_command && !seg_bad) ? DC_W'(DIV_STEPS) : '0;
            end else begin
                if (o_push) begin
                    r_hold <= 1'b0;
                end
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - DC_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ent <= n_ent;
            r_quo <= i_seg_end - i_seg_start;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? DEN_W'(trial - {1'b0, r_ent.den}) : trial[DEN_W-1:0];
            r_quo <= {r_quo[COL_W-2:0], ge};
        end
    end

endmodule

// File: sv/seglr_cmdq.sv
// Short command queue between the front end and the back end.
module seglr_cmdq import seglr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_valid,
    output logic o_full
);

    localparam int PW = $clog2(CQ_DEPTH);
    localparam int CW = PW + 1;

    t_cmd          r_q [CQ_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_head  = r_q[r_rp];
    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CW'(CQ_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

endmodule

// File: sv/seglr_back.sv
// Back end: feature store, sample walker, interpolation pipeline, result queue.
module seglr_back import seglr_pkg::*; #(
    parameter int FEAT_DIM = DEF_FEAT_DIM,
    parameter int COLUMNS  = DEF_COLUMNS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  logic i_cmd_valid,
    output logic o_cmd_pop,
    output t_res o_res,
    output logic o_res_valid,
    input  logic i_res_ready
);

    localparam int ROW_W     = (FEAT_DIM > 1) ? $clog2(FEAT_DIM) : 1;
    localparam int COL_AW    = $clog2(COLUMNS);
    localparam int ADDR_W    = COL_AW + ROW_W;
    localparam int MEM_DEPTH = COLUMNS * (2 ** ROW_W);
    localparam int OQ_PW     = $clog2(OQ_DEPTH);
    localparam int OQ_CW     = OQ_PW + 1;
    localparam int OCC_W     = OQ_CW + 1;
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(FEAT_DIM - 1);

    typedef struct packed {
        logic [SMP_W-1:0]  smp;
        logic [ROW_FW-1:0] row;
        logic              last;
        logic              bad;
        logic [VAL_W-1:0]  frac;
    } t_meta;

    // walker
    t_back_state       r_state, n_state;
    logic [COL_W-1:0]  r_lo, n_lo;
    logic [DEN_W-1:0]  r_rem, n_rem;
    logic [SMP_W-1:0]  r_smp, n_smp;
    logic [ROW_W-1:0]  r_row, n_row;

    // store and pipeline
    logic signed [VAL_W-1:0] r_mem [MEM_DEPTH];
    logic                    r_v1, r_v2;
    t_meta                   r_m1, r_m2;
    logic signed [VAL_W-1:0] r_d0, r_d1;
    logic signed [VAL_W-1:0] r_base;
    logic signed [2*VAL_W+1:0] r_prod;

    // result queue
    t_res             r_oq [OQ_DEPTH];
    logic [OQ_PW-1:0] r_wp, r_rp;
    logic [OQ_CW-1:0] r_oq_cnt;

    logic                  issue;
    logic                  wr_en;
    t_meta                 meta;
    logic [OCC_W-1:0]      occ;
    logic                  can_issue;
    logic [EXT_W-1:0]      lo_ext, hi_ext, wr_ext;
    logic [ADDR_W-1:0]     rd_addr0, rd_addr1, wr_addr;
    logic [DEN_W:0]        rem_sum;
    logic                  row_last, smp_last;
    logic signed [VAL_W:0] diff;
    logic signed [VAL_W:0] frac_s;
    logic signed [VAL_W-1:0] base;
    logic [VAL_W+1:0]      sum;
    t_res                  res_in;
    logic                  oq_pop;

    always_comb begin
        lo_ext   = EXT_W'(r_lo);
        hi_ext   = lo_ext + EXT_W'(1);
        rd_addr0 = {lo_ext[COL_AW-1:0], r_row};
        rd_addr1 = {hi_ext[COL_AW-1:0], r_row};
        wr_ext   = EXT_W'(i_cmd.col);
        wr_addr  = {wr_ext[COL_AW-1:0], i_cmd.row[ROW_W-1:0]};

        // results already in flight must all fit in the result queue
        occ       = OCC_W'(r_oq_cnt) + OCC_W'(r_v1) + OCC_W'(r_v2);
        can_issue = occ < OCC_W'(OQ_DEPTH);

        rem_sum  = {1'b0, r_rem} + {1'b0, i_cmd.r_step};
        row_last = (r_row == ROW_LAST);
        smp_last = (r_smp == i_cmd.den);

        n_state   = r_state;
        n_lo      = r_lo;
        n_rem     = r_rem;
        n_smp     = r_smp;
        n_row     = r_row;
        issue     = 1'b0;
        wr_en     = 1'b0;
        o_cmd_pop = 1'b0;

        meta      = '0;
        meta.smp  = r_smp;
        meta.row  = ROW_FW'(r_row);
        meta.frac = frac_q16(i_cmd.den, r_rem);

        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        K_LOAD: begin
                            wr_en     = 1'b1;
                            o_cmd_pop = 1'b1;
                        end
                        K_BAD: begin
                            meta      = '0;
                            meta.last = 1'b1;
                            meta.bad  = 1'b1;
                            if (can_issue) begin
                                issue     = 1'b1;
                                o_cmd_pop = 1'b1;
                            end
                        end
                        K_SAMPLE: begin
                            n_lo    = i_cmd.col;
                            n_rem   = '0;
                            n_smp   = '0;
                            n_row   = '0;
                            n_state = BK_RUN;
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_RUN: begin
                meta.last = row_last && smp_last;
                if (can_issue) begin
                    issue = 1'b1;
                    if (row_last) begin
                        n_row = '0;
                        if (smp_last) begin
                            o_cmd_pop = 1'b1;
                            n_state   = BK_IDLE;
                        end else begin
                            n_smp = r_smp + SMP_W'(1);
                            // next position: add the step, carry the remainder
                            if (rem_sum >= {1'b0, i_cmd.den}) begin
                                n_rem = DEN_W'(rem_sum - {1'b0, i_cmd.den});
                                n_lo  = r_lo + i_cmd.q_step + COL_W'(1);
                            end else begin
                                n_rem = rem_sum[DEN_W-1:0];
                                n_lo  = r_lo + i_cmd.q_step;
                            end
                        end
                    end else begin
                        n_row = r_row + ROW_W'(1);
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_rem <= n_rem;
        r_smp <= n_smp;
        r_row <= n_row;
    end

    // store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_cmd.value;
        end
        if (issue) begin
            r_d0 <= r_mem[rd_addr0];
            r_d1 <= r_mem[rd_addr1];
        end
    end

    // value = D0 + floor(f * (D1 - D0) / 2^16); the upper column is ignored when f is 0
    always_comb begin
        diff   = (r_m1.bad || (r_m1.frac == '0)) ? '0
                 : ({r_d1[VAL_W-1], r_d1} - {r_d0[VAL_W-1], r_d0});
        frac_s = $signed({1'b0, r_m1.frac});
        base   = r_m1.bad ? '0 : r_d0;
        sum    = {{2{r_base[VAL_W-1]}}, r_base} + r_prod[2*VAL_W+1:VAL_W];

        res_in       = '0;
        res_in.value = sum[VAL_W-1:0];
        res_in.smp   = r_m2.smp;
        res_in.row   = r_m2.row;
        res_in.last  = r_m2.last;
        res_in.bad   = r_m2.bad;

        o_res_valid = (r_oq_cnt != '0);
        o_res       = r_oq[r_rp];
        oq_pop      = o_res_valid && i_res_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_wp     <= '0;
            r_rp     <= '0;
            r_oq_cnt <= '0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            if (r_v2) begin
                r_wp <= r_wp + OQ_PW'(1);
            end
            if (oq_pop) begin
                r_rp <= r_rp + OQ_PW'(1);
            end
            r_oq_cnt <= r_oq_cnt + OQ_CW'(r_v2) - OQ_CW'(oq_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1   <= meta;
        r_m2   <= r_m1;
        r_base <= base;
        r_prod <= diff * frac_s;
        if (r_v2) begin
            r_oq[r_wp] <= res_in;
        end
    end

endmodule

// File: sv/segment_linear_resampler.sv
// Segment linear resampler top level.
// Load beats write one 16-bit element of the feature store; resample beats
// give sample_count samples (clamped to 2..8) along a segment, FEAT_DIM
// results per sample, each interpolated between columns floor(r) and
// floor(r)+1 with a 16-bit fraction, or one result with bad_segment set for
// an invalid segment. The front end takes a resample beat, then a restoring
// divider works out the column step; the back end then makes one store read
// pair per result, and each result passes through the read and product
// registers into the result queue. A four-entry command queue lets the front
// divide the next segment while the back still walks the current one. The
// store needs no clearing after reset and accepts beats at once.
`include "assert_macros.svh"

module segment_linear_resampler import seglr_pkg::*; #(
    parameter int FEAT_DIM = DEF_FEAT_DIM,
    parameter int COLUMNS  = DEF_COLUMNS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CNT_W-1:0]        i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_command,
    input  logic [COL_W-1:0]        i_column,
    input  logic [ROW_FW-1:0]       i_feature_row,
    input  logic signed [VAL_W-1:0] i_sample_value,
    input  logic [COL_W-1:0]        i_seg_start,
    input  logic [COL_W-1:0]        i_seg_end,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [VAL_W-1:0] o_feature_value,
    output logic [SMP_W-1:0]        o_sample_number,
    output logic [ROW_FW-1:0]       o_out_row,
    output logic                    o_last,
    output logic                    o_bad_segment
);

    logic [CNT_W-1:0] r_sample_count;

    t_cmd w_fe_cmd;
    logic w_cq_push;
    logic w_cq_full;
    t_cmd w_cq_head;
    logic w_cq_valid;
    logic w_cq_pop;
    t_res w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= SC_RESET;
        end else if (i_cfg_valid) begin
            r_sample_count <= i_cfg_data;
        end
    end

    seglr_front #(
        .FEAT_DIM (FEAT_DIM),
        .COLUMNS  (COLUMNS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_column       (i_column),
        .i_feature_row  (i_feature_row),
        .i_sample_value (i_sample_value),
        .i_seg_start    (i_seg_start),
        .i_seg_end      (i_seg_end),
        .i_sample_count (r_sample_count),
        .o_cmd          (w_fe_cmd),
        .o_push         (w_cq_push),
        .i_q_full       (w_cq_full)
    );

    seglr_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cq_push),
        .i_cmd   (w_fe_cmd),
        .i_pop   (w_cq_pop),
        .o_head  (w_cq_head),
        .o_valid (w_cq_valid),
        .o_full  (w_cq_full)
    );

    seglr_back #(
        .FEAT_DIM (FEAT_DIM),
        .COLUMNS  (COLUMNS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cq_head),
        .i_cmd_valid (w_cq_valid),
        .o_cmd_pop   (w_cq_pop),
        .o_res       (w_res),
        .o_res_valid (o_valid),
        .i_res_ready (i_ready)
    );

    assign o_feature_value = w_res.value;
    assign o_sample_number = w_res.smp;
    assign o_out_row       = w_res.row;
    assign o_last          = w_res.last;
    assign o_bad_segment   = w_res.bad;

    `ASSERT_IMPLIES(a_cq_no_overflow, i_clk, i_rst_n, w_cq_push, !w_cq_full, "command queue overflow")
    `ASSERT_IMPLIES(a_cq_no_underflow, i_clk, i_rst_n, w_cq_pop, w_cq_valid, "command queue underflow")
    `ASSERT_NEXT(a_cq_fills, i_clk, i_rst_n, w_cq_push && !w_cq_pop, w_cq_valid, "pushed command lost")
    `ASSERT_IMPLIES(a_bad_result, i_clk, i_rst_n, o_valid && o_bad_segment, o_last && (o_feature_value == '0) && (o_sample_number == '0) && (o_out_row == '0), "bad segment beat malformed")

endmodule
